>>> hw/rtl/rlc_pkg.sv
// package: shared types, constants and helper functions of the lowpass coefficient designer
`default_nettype none
package rlc_pkg;

    localparam int COEF_WIDTH = 32;
    localparam int FS_W       = 18;
    localparam int CUT_W      = 17;
    localparam int Q_W        = 16;
    localparam int CORDIC_W   = 34;
    localparam int CORDIC_N   = 31;
    localparam logic [17:0] FS_RESET = 18'd44100;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic [CUT_W-1:0] cutoff_hz;
        logic [Q_W-1:0]   resonance_q;
    } t_req;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_b0;
        logic signed [COEF_WIDTH-1:0] coef_b1;
        logic signed [COEF_WIDTH-1:0] coef_b2;
        logic signed [COEF_WIDTH-1:0] coef_a1;
        logic signed [COEF_WIDTH-1:0] coef_a2;
        logic                         range_error;
    } t_rsp;

    // arctangent of 2^-i in turns scaled by 2^32
    function automatic logic [29:0] atan_turns(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051D;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2E;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2F9;
            5'd15: v = 30'h0000517C;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A2F;
            5'd19: v = 30'h00000517;
            5'd20: v = 30'h0000028B;
            5'd21: v = 30'h00000145;
            5'd22: v = 30'h000000A2;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000028;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000002;
            5'd29: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    localparam int SHL = (COEF_WIDTH >= 32) ? COEF_WIDTH - 32 : 0;
    localparam int SHR = (COEF_WIDTH < 32) ? 32 - COEF_WIDTH : 1;

    // saturate a Q2.30 value to 32 bits, then rescale to the coefficient width
    function automatic logic signed [COEF_WIDTH-1:0] to_coef(input logic signed [34:0] v);
        logic signed [31:0] v32;
        logic signed [32:0] t;
        logic signed [32:0] lim;
        logic signed [COEF_WIDTH-1:0] r;
        if (v > 35'sd2147483647) begin
            v32 = 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            v32 = 32'sh80000000;
        end else begin
            v32 = v[31:0];
        end
        if (COEF_WIDTH >= 32) begin
            r = COEF_WIDTH'(v32) <<< SHL;
        end else begin
            t   = (33'(v32) + (33'sd1 <<< (SHR - 1))) >>> SHR;
            lim = (33'sd1 <<< (COEF_WIDTH - 1)) - 33'sd1;
            if (t > lim) begin
                t = lim;
            end
            r = COEF_WIDTH'(t);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/resonant_lowpass_coef_design.sv
// resonant lowpass coefficient designer: phase divider, cordic, alpha divider, coefficient dividers
// pipeline: 136 register stages from the input transfer to the result on o_valid
// throughput: one request per cycle; the whole pipeline holds while the output is stalled
// the depth is set by the bit-per-stage dividers (32 + 38 + 32) and the 31-stage cordic
// reset: synchronous active low, clears all valid bits and loads a 44100 Hz sample rate
`default_nettype none
module resonant_lowpass_coef_design (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire rlc_pkg::t_req                    i_data,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output rlc_pkg::t_rsp                         o_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [rlc_pkg::FS_W-1:0]         i_cfg_data
);

    localparam int W = rlc_pkg::CORDIC_W;

    logic en;
    logic [rlc_pkg::FS_W-1:0] r_fs;
    logic r_out_valid;
    rlc_pkg::t_rsp r_out;

    assign en          = !(r_out_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= rlc_pkg::FS_RESET;
        end else if (i_cfg_valid) begin
            r_fs <= i_cfg_data;
        end
    end

    // phase divider: p = f * 2^32 / fs
    logic in_err;
    logic [0:0][48:0] ph_num;
    logic [0:0][17:0] ph_div;
    logic ph_valid;
    logic [0:0][31:0] ph_quo;
    logic [16:0] ph_side;

    assign in_err    = (i_data.cutoff_hz == '0) || ({1'b0, i_data.cutoff_hz, 1'b0} >= 19'(r_fs));
    assign ph_num[0] = {i_data.cutoff_hz, 32'd0};
    assign ph_div[0] = r_fs;

    rlc_div #(.N(49), .Q(32), .D(18), .L(1), .S(17)) u_phase_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid && en),
        .i_num   (ph_num),
        .i_div   (ph_div),
        .i_side  ({i_data.resonance_q, in_err}),
        .o_valid (ph_valid),
        .o_quo   (ph_quo),
        .o_side  (ph_side)
    );

    // sine and cosine, angle taken from a quarter turn
    logic signed [W-1:0] cz;
    logic co_valid;
    logic signed [W-1:0] co_x, co_y;
    logic [16:0] co_side;

    assign cz = signed'(W'(ph_quo[0])) - (W'(1) <<< 30);

    rlc_cordic #(.S(17)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ph_valid),
        .i_z     (cz),
        .i_side  (ph_side),
        .o_valid (co_valid),
        .o_x     (co_x),
        .o_y     (co_y),
        .o_side  (co_side)
    );

    // clamp stage
    logic signed [W-1:0] ny;
    logic [30:0] n_s;
    logic signed [31:0] n_c;
    logic [15:0] n_q;
    logic r_cl_valid;
    logic [30:0] r_s;
    logic signed [31:0] r_c;
    logic [15:0] r_q;
    logic r_cl_err;

    always_comb begin
        ny = -co_y;
        if (co_x < 0) begin
            n_s = '0;
        end else if (co_x > (W'(1) <<< 30)) begin
            n_s = 31'd1 << 30;
        end else begin
            n_s = co_x[30:0];
        end
        if (ny > (signed'(W'(1)) <<< 30)) begin
            n_c = 32'sd1 <<< 30;
        end else if (ny < -(signed'(W'(1)) <<< 30)) begin
            n_c = -(32'sd1 <<< 30);
        end else begin
            n_c = ny[31:0];
        end
        // zero resonance is treated as the smallest step
        n_q = (co_side[16:1] == '0) ? 16'd1 : co_side[16:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cl_valid <= 1'b0;
        end else if (en) begin
            r_cl_valid <= co_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s      <= n_s;
            r_c      <= n_c;
            r_q      <= n_q;
            r_cl_err <= co_side[0];
        end
    end

    // alpha = s * 128 / q
    logic [0:0][37:0] al_num;
    logic [0:0][15:0] al_div;
    logic al_valid;
    logic [0:0][37:0] al_quo;
    logic [32:0] al_side;

    assign al_num[0] = {r_s, 7'd0};
    assign al_div[0] = r_q;

    rlc_div #(.N(38), .Q(38), .D(16), .L(1), .S(33)) u_alpha_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_cl_valid),
        .i_num   (al_num),
        .i_div   (al_div),
        .i_side  ({r_c, r_cl_err}),
        .o_valid (al_valid),
        .o_quo   (al_quo),
        .o_side  (al_side)
    );

    // numerator stage
    logic signed [31:0] al_c;
    logic [37:0] den;
    logic [37:0] half;
    logic [31:0] omc;
    logic [30:0] mag;
    logic r_nm_valid;
    logic [2:0][61:0] r_num;
    logic [37:0] r_den;
    logic r_cpos;
    logic r_nm_err;

    always_comb begin
        al_c = signed'(al_side[32:1]);
        den  = 38'((39'(al_quo[0])) + (39'd1 << 30));
        half = den >> 1;
        omc  = 32'((33'sd1 <<< 30) - 33'(al_c));
        mag  = (al_c < 0) ? 31'(-33'(al_c)) : al_c[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_valid <= 1'b0;
        end else if (en) begin
            r_nm_valid <= al_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num[0] <= 62'({omc, 29'd0}) + 62'(half);
            r_num[1] <= {mag, 31'd0} + 62'(half);
            r_num[2] <= (62'd1 << 61) + 62'(half);
            r_den    <= den;
            r_cpos   <= (al_c > 0);
            r_nm_err <= al_side[0];
        end
    end

    // b0, a1 and a2 quotients in three lanes
    logic [2:0][37:0] cf_div;
    logic cf_valid;
    logic [2:0][31:0] cf_quo;
    logic [1:0] cf_side;

    assign cf_div = {r_den, r_den, r_den};

    rlc_div #(.N(62), .Q(32), .D(38), .L(3), .S(2)) u_coef_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_nm_valid),
        .i_num   (r_num),
        .i_div   (cf_div),
        .i_side  ({r_cpos, r_nm_err}),
        .o_valid (cf_valid),
        .o_quo   (cf_quo),
        .o_side  (cf_side)
    );

    // output register
    logic signed [34:0] vb0, vb1, va1, va2;
    rlc_pkg::t_rsp n_out;

    always_comb begin
        vb0 = signed'(35'(cf_quo[0]));
        vb1 = vb0 <<< 1;
        va1 = cf_side[1] ? -signed'(35'(cf_quo[1])) : signed'(35'(cf_quo[1]));
        va2 = signed'(35'(cf_quo[2])) - (35'sd1 <<< 30);
        if (cf_side[0]) begin
            n_out = '0;
            n_out.range_error = 1'b1;
        end else begin
            n_out.coef_b0     = rlc_pkg::to_coef(vb0);
            n_out.coef_b1     = rlc_pkg::to_coef(vb1);
            n_out.coef_b2     = rlc_pkg::to_coef(vb0);
            n_out.coef_a1     = rlc_pkg::to_coef(va1);
            n_out.coef_a2     = rlc_pkg::to_coef(va2);
            n_out.range_error = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= cf_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_stall_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("upstream stall does not follow output backpressure");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.range_error) |-> (o_data.coef_b0 == '0 && o_data.coef_b1 == '0
            && o_data.coef_b2 == '0 && o_data.coef_a1 == '0 && o_data.coef_a2 == '0))
        else $error("range error result carries nonzero coefficients");

    a_b2_eq_b0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.coef_b2 == o_data.coef_b0))
        else $error("b2 differs from b0");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> $stable(r_out_valid) || !o_stall)
        else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

>>> hw/rtl/rlc_div.sv
// pipelined restoring divider, one quotient bit per stage, several lanes in lockstep
`default_nettype none
module rlc_div #(
    parameter int N = 49,
    parameter int Q = 32,
    parameter int D = 18,
    parameter int L = 1,
    parameter int S = 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic [L-1:0][N-1:0]     i_num,
    input  wire logic [L-1:0][D-1:0]     i_div,
    input  wire logic [S-1:0]            i_side,
    output logic                         o_valid,
    output logic [L-1:0][Q-1:0]          o_quo,
    output logic [S-1:0]                 o_side
);

    logic                r_valid [0:Q-1];
    logic [L-1:0][D-1:0] r_rem   [0:Q-1];
    logic [L-1:0][N-1:0] r_num   [0:Q-1];
    logic [L-1:0][D-1:0] r_div   [0:Q-1];
    logic [L-1:0][Q-1:0] r_quo   [0:Q-1];
    logic [S-1:0]        r_side  [0:Q-1];

    for (genvar k = 0; k < Q; k++) begin : g_stage
        logic                p_valid;
        logic [L-1:0][D-1:0] p_rem;
        logic [L-1:0][N-1:0] p_num;
        logic [L-1:0][D-1:0] p_div;
        logic [L-1:0][Q-1:0] p_quo;
        logic [S-1:0]        p_side;
        logic [L-1:0][D-1:0] n_rem;
        logic [L-1:0][Q-1:0] n_quo;

        if (k == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_num   = i_num;
            assign p_div   = i_div;
            assign p_side  = i_side;
            assign p_quo   = '0;
            for (genvar l = 0; l < L; l++) begin : g_init
                assign p_rem[l] = D'(i_num[l] >> Q);
            end
        end else begin : g_next
            assign p_valid = r_valid[k-1];
            assign p_rem   = r_rem[k-1];
            assign p_num   = r_num[k-1];
            assign p_div   = r_div[k-1];
            assign p_quo   = r_quo[k-1];
            assign p_side  = r_side[k-1];
        end

        for (genvar l = 0; l < L; l++) begin : g_lane
            logic [D:0]   t;
            logic [D-1:0] l_rem;
            logic [Q-1:0] l_quo;
            always_comb begin
                t     = {p_rem[l], p_num[l][Q-1-k]};
                l_quo = p_quo[l];
                if (t >= {1'b0, p_div[l]}) begin
                    l_rem        = D'(t - {1'b0, p_div[l]});
                    l_quo[Q-1-k] = 1'b1;
                end else begin
                    l_rem        = t[D-1:0];
                end
            end
            assign n_rem[l] = l_rem;
            assign n_quo[l] = l_quo;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_num[k]  <= p_num;
                r_div[k]  <= p_div;
                r_quo[k]  <= n_quo;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_valid[Q-1];
    assign o_quo   = r_quo[Q-1];
    assign o_side  = r_side[Q-1];

endmodule
`default_nettype wire

>>> hw/rtl/rlc_cordic.sv
// pipelined rotation-mode cordic giving sine and cosine of a phase in turns
`default_nettype none
module rlc_cordic #(
    parameter int S = 17
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_en,
    input  wire logic                                    i_valid,
    input  wire logic signed [rlc_pkg::CORDIC_W-1:0]     i_z,
    input  wire logic [S-1:0]                            i_side,
    output logic                                         o_valid,
    output logic signed [rlc_pkg::CORDIC_W-1:0]          o_x,
    output logic signed [rlc_pkg::CORDIC_W-1:0]          o_y,
    output logic [S-1:0]                                 o_side
);

    localparam int W  = rlc_pkg::CORDIC_W;
    localparam int NS = rlc_pkg::CORDIC_N;

    logic                r_valid [0:NS-1];
    logic signed [W-1:0] r_x     [0:NS-1];
    logic signed [W-1:0] r_y     [0:NS-1];
    logic signed [W-1:0] r_z     [0:NS-1];
    logic [S-1:0]        r_side  [0:NS-1];

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic                p_valid;
        logic signed [W-1:0] p_x, p_y, p_z;
        logic [S-1:0]        p_side;
        logic signed [W-1:0] dx, dy, at;
        logic signed [W-1:0] n_x, n_y, n_z;

        if (i == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_x     = rlc_pkg::CORDIC_X0;
            assign p_y     = '0;
            assign p_z     = i_z;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_valid = r_valid[i-1];
            assign p_x     = r_x[i-1];
            assign p_y     = r_y[i-1];
            assign p_z     = r_z[i-1];
            assign p_side  = r_side[i-1];
        end

        always_comb begin
            dx = p_y >>> i;
            dy = p_x >>> i;
            at = signed'(W'(rlc_pkg::atan_turns(5'(i))));
            if (p_z >= 0) begin
                n_x = p_x - dx;
                n_y = p_y + dy;
                n_z = p_z - at;
            end else begin
                n_x = p_x + dx;
                n_y = p_y - dy;
                n_z = p_z + at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else if (i_en) begin
                r_valid[i] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i]    <= n_x;
                r_y[i]    <= n_y;
                r_z[i]    <= n_z;
                r_side[i] <= p_side;
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_x     = r_x[NS-1];
    assign o_y     = r_y[NS-1];
    assign o_side  = r_side[NS-1];

endmodule
`default_nettype wire

>>> dv/tb_resonant_lowpass_coef_design.sv
// testbench: lowpass coefficient designer checked against a bit-exact predictor
`timescale 1ns / 1ps
module tb_resonant_lowpass_coef_design;

    localparam longint ONE_Q30 = 64'sd1 <<< 30;
    localparam longint ATAN_TURNS [0:30] = '{
        'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
        'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
        'h00000028, 'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001,
        'h00000000};

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    rlc_pkg::t_req               i_data;
    logic                        o_valid;
    logic                        i_stall;
    rlc_pkg::t_rsp               o_data;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [rlc_pkg::FS_W-1:0]    i_cfg_data;

    logic [rlc_pkg::FS_W-1:0]    model_fs;
    rlc_pkg::t_rsp               coef_q[$];
    int                          err_count;
    int                          hold_cycles;
    int                          stall_mode;

    resonant_lowpass_coef_design i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[resonant_lowpass_coef_design] ERROR");
        $finish;
    end

    // saturate to Q2.30 in 32 bits, then rescale to the coefficient width
    function automatic logic [rlc_pkg::COEF_WIDTH-1:0] sat_coef(input longint v);
        longint lim;
        longint r;
        int     sh;
        lim = 64'sd1 <<< (rlc_pkg::COEF_WIDTH - 1);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        if (rlc_pkg::COEF_WIDTH >= 32) begin
            sh = rlc_pkg::COEF_WIDTH - 32;
            r = v <<< sh;
        end else begin
            sh = 32 - rlc_pkg::COEF_WIDTH;
            r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        end
        if (r > lim - 1) r = lim - 1;
        if (r < -lim) r = -lim;
        return r[rlc_pkg::COEF_WIDTH-1:0];
    endfunction

    function automatic rlc_pkg::t_rsp design_coefs(input rlc_pkg::t_req r,
                                                   input logic [rlc_pkg::FS_W-1:0] fs);
        rlc_pkg::t_rsp o;
        longint f, q, fsl, z, x, y, dx, dy, s, c, alpha, den, b0, a1, a2, mag;
        o = '0;
        f = r.cutoff_hz;
        q = r.resonance_q;
        fsl = fs;
        if (f == 0 || 2 * f >= fsl) begin
            o.range_error = 1'b1;
            return o;
        end
        if (q == 0) q = 1;
        z = (f <<< 32) / fsl - ONE_Q30;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 31; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_TURNS[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_TURNS[i];
            end
        end
        s = (x < 0) ? 0 : ((x > ONE_Q30) ? ONE_Q30 : x);
        c = -y;
        if (c < -ONE_Q30) c = -ONE_Q30;
        if (c > ONE_Q30) c = ONE_Q30;
        alpha = (s * 128) / q;
        den = ONE_Q30 + alpha;
        b0 = ((ONE_Q30 - c) * (64'sd1 <<< 29) + den / 2) / den;
        mag = (c < 0) ? -c : c;
        a1 = (mag * (64'sd1 <<< 31) + den / 2) / den;
        if (c > 0) a1 = -a1;
        a2 = ((64'sd1 <<< 61) + den / 2) / den - ONE_Q30;
        o.coef_b0 = sat_coef(b0);
        o.coef_b1 = sat_coef(2 * b0);
        o.coef_b2 = sat_coef(b0);
        o.coef_a1 = sat_coef(a1);
        o.coef_a2 = sat_coef(a2);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // result checker
    always @(posedge i_clk) begin
        rlc_pkg::t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (coef_q.size() == 0) begin
                report_mismatch("unexpected result", o_data.coef_b0, 0);
            end else begin
                want = coef_q.pop_front();
                if (o_data.coef_b0 !== want.coef_b0)
                    report_mismatch("coef_b0", o_data.coef_b0, want.coef_b0);
                if (o_data.coef_b1 !== want.coef_b1)
                    report_mismatch("coef_b1", o_data.coef_b1, want.coef_b1);
                if (o_data.coef_b2 !== want.coef_b2)
                    report_mismatch("coef_b2", o_data.coef_b2, want.coef_b2);
                if (o_data.coef_a1 !== want.coef_a1)
                    report_mismatch("coef_a1", o_data.coef_a1, want.coef_a1);
                if (o_data.coef_a2 !== want.coef_a2)
                    report_mismatch("coef_a2", o_data.coef_a2, want.coef_a2);
                if (o_data.range_error !== want.range_error)
                    report_mismatch("range_error", o_data.range_error, want.range_error);
            end
        end
    end

    // receiver stall pattern; a long hold-off overrides it
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            case (stall_mode)
                0: begin
                    i_stall <= 1'b0;
                end
                1: begin
                    i_stall <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    i_stall <= ($urandom_range(0, 9) < 6);
                end
            endcase
        end
    end

    task automatic send_req(input rlc_pkg::t_req r);
        i_valid <= 1'b1;
        i_data  <= r;
        do @(posedge i_clk); while (o_stall);
        coef_q.push_back(design_coefs(r, model_fs));
    endtask

    task automatic idle_sender(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (coef_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [rlc_pkg::FS_W-1:0] fs);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= fs;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 18'($urandom());
        model_fs = fs;
        @(posedge i_clk);
    endtask

    task automatic set_stall_mode(input int m);
        @(negedge i_clk);
        stall_mode = m;
        @(posedge i_clk);
    endtask

    function automatic rlc_pkg::t_req mk_req(input int f, input int q);
        rlc_pkg::t_req r;
        r.cutoff_hz   = 17'(f);
        r.resonance_q = 16'(q);
        return r;
    endfunction

    function automatic rlc_pkg::t_req rand_req(input logic [rlc_pkg::FS_W-1:0] fs);
        rlc_pkg::t_req r;
        int   pick;
        int   fmax;
        pick = $urandom_range(0, 99);
        fmax = (fs > 2) ? (int'(fs) - 1) / 2 : 1;
        if (fmax > 131071) fmax = 131071;
        if (pick < 4) r.cutoff_hz = '0;
        else if (pick < 10) r.cutoff_hz = 17'($urandom());
        else if (pick < 15) r.cutoff_hz = 17'(fmax - int'($urandom_range(0, 3)));
        else r.cutoff_hz = 17'($urandom_range(1, fmax));
        pick = $urandom_range(0, 99);
        if (pick < 5) r.resonance_q = '0;
        else if (pick < 20) r.resonance_q = 16'($urandom());
        else r.resonance_q = 16'($urandom_range(32, 4096));
        return r;
    endfunction

    task automatic test_reset_rate();
        set_stall_mode(0);
        send_req(mk_req(0, 256));
        send_req(mk_req(1, 256));
        send_req(mk_req(22049, 181));
        send_req(mk_req(22050, 181));
        send_req(mk_req(131071, 65535));
        send_req(mk_req(1000, 0));
        send_req(mk_req(1000, 1));
        send_req(mk_req(1000, 65535));
        send_req(mk_req(11025, 256));
        send_req(mk_req(5000, 2560));
        wait_drain();
    endtask

    task automatic test_rate_extremes();
        write_rate(18'd8000);
        send_req(mk_req(3999, 256));
        send_req(mk_req(4000, 256));
        send_req(mk_req(1, 65535));
        send_req(mk_req(2000, 0));
        write_rate(18'd192000);
        send_req(mk_req(95999, 1));
        send_req(mk_req(96000, 181));
        send_req(mk_req(20000, 700));
        write_rate(18'd262143);
        send_req(mk_req(131071, 65535));
        send_req(mk_req(65536, 21845));
        send_req(mk_req(43690, 43690));
        // a zero sample rate makes every cutoff out of range
        write_rate(18'd0);
        send_req(mk_req(1, 256));
        send_req(mk_req(131071, 0));
        wait_drain();
    endtask

    task automatic run_bursts(input int n);
        int burst;
        burst = 0;
        for (int k = 0; k < n; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 8));
            end
            send_req(rand_req(model_fs));
            burst--;
        end
    endtask

    task automatic test_backpressure();
        write_rate(18'd48000);
        set_stall_mode(0);
        @(negedge i_clk);
        hold_cycles = 400;
        @(posedge i_clk);
        // sender keeps offering through the hold-off until the pipeline is full
        for (int k = 0; k < 200; k++) send_req(rand_req(model_fs));
        i_valid <= 1'b0;
        // pause until every transfer has come out
        wait_drain();
    endtask

    task automatic test_random();
        logic [rlc_pkg::FS_W-1:0] rates [0:5];
        rates = '{18'd44100, 18'd8000, 18'd192000, 18'd96000, 18'd0, 18'd0};
        rates[4] = 18'($urandom_range(8000, 192000));
        rates[5] = 18'($urandom_range(8000, 192000));
        for (int p = 0; p < 6; p++) begin
            write_rate(rates[p]);
            set_stall_mode(p % 3);
            run_bursts(46);
        end
        wait_drain();
    endtask

    initial begin
        err_count   = 0;
        hold_cycles = 0;
        stall_mode  = 0;
        model_fs    = 18'd44100;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_rate();
        test_rate_extremes();
        test_backpressure();
        test_random();
        repeat (150) @(posedge i_clk);
        if (err_count == 0 && coef_q.size() == 0) begin
            $display("[resonant_lowpass_coef_design] OK");
        end else begin
            $display("[resonant_lowpass_coef_design] ERROR");
        end
        $finish;
    end
endmodule
